>>> rtl/core/button_debounce_long_press_repeat_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BDLPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BDLPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bdlpr_pkg.sv
package bdlpr_pkg;

    localparam int BDLPR_NUM_BUTTONS = 2;
    localparam int BDLPR_BTN_W       = 2;
    localparam int BDLPR_TICK_W      = 32;
    localparam int BDLPR_CFG_W       = 16;
    localparam int BDLPR_CFG_IDX_W   = 2;

    // register indexes of the configuration port
    localparam logic [BDLPR_CFG_IDX_W-1:0] BDLPR_REG_DEBOUNCE = 2'd0;
    localparam logic [BDLPR_CFG_IDX_W-1:0] BDLPR_REG_LONG     = 2'd1;
    localparam logic [BDLPR_CFG_IDX_W-1:0] BDLPR_REG_REPEAT   = 2'd2;

    localparam logic [BDLPR_CFG_W-1:0] BDLPR_DEBOUNCE_RST = 16'd50;
    localparam logic [BDLPR_CFG_W-1:0] BDLPR_LONG_RST     = 16'd1000;
    localparam logic [BDLPR_CFG_W-1:0] BDLPR_REPEAT_RST   = 16'd200;

    typedef struct packed {
        logic [BDLPR_BTN_W-1:0] raw_levels;
        logic [BDLPR_BTN_W-1:0] take_press_mask;
        logic [BDLPR_BTN_W-1:0] take_long_mask;
    } bdlpr_in_t;

    typedef struct packed {
        logic [BDLPR_BTN_W-1:0] stable_levels;
        logic [BDLPR_BTN_W-1:0] press_taken;
        logic [BDLPR_BTN_W-1:0] long_taken;
    } bdlpr_out_t;

    typedef struct packed {
        logic [BDLPR_CFG_W-1:0] debounce_ticks;
        logic [BDLPR_CFG_W-1:0] long_press_ticks;
        logic [BDLPR_CFG_W-1:0] repeat_ticks;
    } bdlpr_cfg_t;

    // per-button slice of one tick
    typedef struct packed {
        logic raw;
        logic take_press;
        logic take_long;
    } bdlpr_key_in_t;

    typedef struct packed {
        logic stable;
        logic press_taken;
        logic long_taken;
    } bdlpr_key_out_t;

endpackage

>>> rtl/core/bdlpr_key.sv
module bdlpr_key
    import bdlpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  bdlpr_key_in_t           key_in,
    input  logic [BDLPR_TICK_W-1:0] now,
    input  bdlpr_cfg_t              cfg,
    output bdlpr_key_out_t          key_out
);

    logic                    last_raw_reg, last_raw_next;
    logic                    stable_reg, stable_next;
    logic [BDLPR_TICK_W-1:0] change_time_reg, change_time_next;
    logic [BDLPR_TICK_W-1:0] press_time_reg, press_time_next;
    logic [BDLPR_TICK_W-1:0] repeat_time_reg, repeat_time_next;
    logic                    press_pend_reg, press_pend_next;
    logic                    long_pend_reg, long_pend_next;
    logic                    armed_reg, armed_next;

    logic [BDLPR_TICK_W-1:0] db_elapsed;
    logic [BDLPR_TICK_W-1:0] lp_elapsed;
    logic [BDLPR_TICK_W-1:0] rp_elapsed;
    logic                    db_done;

    always_comb
    begin
        last_raw_next    = key_in.raw;
        change_time_next = (key_in.raw != last_raw_reg) ? now : change_time_reg;
        stable_next      = stable_reg;
        press_time_next  = press_time_reg;
        repeat_time_next = repeat_time_reg;
        press_pend_next  = press_pend_reg;
        long_pend_next   = long_pend_reg;
        armed_next       = armed_reg;

        // debounce, elapsed time wraps modulo 2^32
        db_elapsed = now - change_time_next;
        db_done    = (db_elapsed >= {{(BDLPR_TICK_W-BDLPR_CFG_W){1'b0}}, cfg.debounce_ticks})
                     && (key_in.raw != stable_reg);
        if (db_done)
        begin
            stable_next = key_in.raw;
            armed_next  = 1'b0;
            if (!key_in.raw)
            begin
                press_pend_next  = 1'b1;
                long_pend_next   = 1'b0;
                press_time_next  = now;
                repeat_time_next = now;
            end
        end

        // long press and auto-repeat while held
        lp_elapsed = now - press_time_next;
        rp_elapsed = now - repeat_time_next;
        if (!stable_next)
        begin
            if (!armed_next && (lp_elapsed >=
                {{(BDLPR_TICK_W-BDLPR_CFG_W){1'b0}}, cfg.long_press_ticks}))
            begin
                long_pend_next   = 1'b1;
                armed_next       = 1'b1;
                repeat_time_next = now;
            end
            else if (armed_next && (rp_elapsed >=
                {{(BDLPR_TICK_W-BDLPR_CFG_W){1'b0}}, cfg.repeat_ticks}))
            begin
                press_pend_next  = 1'b1;
                repeat_time_next = now;
            end
        end

        // takes see events latched in this same tick
        key_out.stable      = stable_next;
        key_out.press_taken = key_in.take_press & press_pend_next;
        key_out.long_taken  = key_in.take_long & long_pend_next;
        if (key_in.take_press)
        begin
            press_pend_next = 1'b0;
        end
        if (key_in.take_long)
        begin
            long_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b1;
            stable_reg      <= 1'b1;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
            press_pend_reg  <= 1'b0;
            long_pend_reg   <= 1'b0;
            armed_reg       <= 1'b0;
        end
        else if (en)
        begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            repeat_time_reg <= repeat_time_next;
            press_pend_reg  <= press_pend_next;
            long_pend_reg   <= long_pend_next;
            armed_reg       <= armed_next;
        end
    end

endmodule

>>> rtl/core/button_debounce_long_press_repeat_unit.sv
// Button debouncer with long-press events and auto-repeat.
// Input channel (in_valid/in_ready/in_data): one transaction per millisecond
// tick, carrying the raw active-low button levels and the masks that take
// pending press and long events.
// Output channel (out_valid/out_ready/out_data): one transaction per tick with
// the debounced levels and the events taken in that tick.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 debounce, 1 long press, 2 repeat period; other indexes are ignored.
// Write it only while no tick is in flight.
// A tick accepted into the input register is updated per button and lands in
// the result register. Throughput: one tick per cycle while out_ready is high,
// set by the single input register feeding the update and the result register.
// Reset: all buttons released, no events pending, tick counter at zero,
// timing registers at 50, 1000 and 200 ticks.
// Stall: while out_ready is low the result holds, the input register keeps one
// more tick and in_ready drops once both are full; no tick is lost.
module button_debounce_long_press_repeat_unit
    import bdlpr_pkg::*;
#(
    parameter int NUM_BUTTONS = BDLPR_NUM_BUTTONS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bdlpr_in_t                  in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bdlpr_out_t                 out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [BDLPR_CFG_IDX_W-1:0] cfg_index,
    input  logic [BDLPR_CFG_W-1:0]     cfg_data
);

    `include "button_debounce_long_press_repeat_unit_macros.svh"

    localparam int KEYS = (NUM_BUTTONS < BDLPR_BTN_W) ? NUM_BUTTONS : BDLPR_BTN_W;

    logic                    in_valid_reg;
    bdlpr_in_t               in_item_reg;
    logic                    out_valid_reg;
    bdlpr_out_t              out_item_reg, out_item_next;
    logic [BDLPR_TICK_W-1:0] tick_reg;
    bdlpr_cfg_t              cfg_reg;
    logic                    advance;

    logic [BDLPR_BTN_W-1:0]  stable_bits;
    logic [BDLPR_BTN_W-1:0]  press_bits;
    logic [BDLPR_BTN_W-1:0]  long_bits;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    for (genvar i = 0; i < BDLPR_BTN_W; i++)
    begin : g_key
        if (i < KEYS)
        begin : g_on
            bdlpr_key_in_t  key_in;
            bdlpr_key_out_t key_out;

            assign key_in.raw        = in_item_reg.raw_levels[i];
            assign key_in.take_press = in_item_reg.take_press_mask[i];
            assign key_in.take_long  = in_item_reg.take_long_mask[i];

            bdlpr_key u_key
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .key_in  (key_in),
                .now     (tick_reg),
                .cfg     (cfg_reg),
                .key_out (key_out)
            );

            assign stable_bits[i] = key_out.stable;
            assign press_bits[i]  = key_out.press_taken;
            assign long_bits[i]   = key_out.long_taken;
        end
        else
        begin : g_off
            assign stable_bits[i] = 1'b0;
            assign press_bits[i]  = 1'b0;
            assign long_bits[i]   = 1'b0;
        end
    end

    always_comb
    begin
        out_item_next.stable_levels = stable_bits;
        out_item_next.press_taken   = press_bits;
        out_item_next.long_taken    = long_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_reg + BDLPR_TICK_W'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= BDLPR_DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= BDLPR_LONG_RST;
            cfg_reg.repeat_ticks     <= BDLPR_REPEAT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                BDLPR_REG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_data;
                BDLPR_REG_LONG:     cfg_reg.long_press_ticks <= cfg_data;
                BDLPR_REG_REPEAT:   cfg_reg.repeat_ticks     <= cfg_data;
                default:            ;
            endcase
        end
    end

    `BDLPR_ASSERT_NEXT(a_stage_holds, clk, rst_n, in_valid_reg && !advance, in_valid_reg, "tick dropped from input register")
    `BDLPR_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_valid_reg, "result missing after advance")
    `BDLPR_ASSERT_NEXT(a_tick_counts, clk, rst_n, advance, tick_reg == $past(tick_reg) + BDLPR_TICK_W'(1), "tick counter out of step")
    `BDLPR_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !advance, "stalled result overwritten")

endmodule
